/* hw/rtl/smm_pkg.sv */
`default_nettype none

package smm_pkg;

   localparam int IDX_W  = 3;
   localparam int SIZE_W = 4;
   localparam int DATA_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 35;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   localparam logic REG_MATRIX_SIZE = 1'b0;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } smm_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } smm_state_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } smm_tag_type;

endpackage

`default_nettype wire

/* hw/rtl/smm_ram.sv */
`default_nettype none

module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/smm_seq.sv */
`default_nettype none

module smm_seq #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start_compute,
   input  wire logic [smm_pkg::SIZE_W-1:0]          size,
   output logic                                     busy,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_a,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_b,
   output smm_pkg::smm_tag_type                     tag
);

   import smm_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   smm_state_type     state_ff, state_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              i_last, j_last, k_last;

   assign i_last = ({1'b0, i_ff} == n_ff - SIZE_W'(1));
   assign j_last = ({1'b0, j_ff} == n_ff - SIZE_W'(1));
   assign k_last = ({1'b0, k_ff} == n_ff - SIZE_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_compute && size != '0) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (i_last && j_last && k_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (state_ff == ST_IDLE) begin
         n_in = size;
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (k_last) begin
         k_in = '0;
         if (j_last) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end else begin
         k_in = k_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   always_comb begin
      busy          = (state_ff == ST_RUN);
      rd_addr_a     = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
      rd_addr_b     = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));
      tag.valid     = (state_ff == ST_RUN);
      tag.first     = (k_ff == '0);
      tag.last_k    = k_last;
      tag.last_elem = i_last && j_last;
      tag.row       = i_ff;
      tag.col       = j_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ({1'b0, k_ff} < n_ff) && ({1'b0, j_ff} < n_ff)
                               && ({1'b0, i_ff} < n_ff))
      else $error("Loop counter reached the matrix size.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (n_ff != '0) && (n_ff <= SIZE_W'(MAX_DIM)))
      else $error("Running with an invalid matrix size.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start_compute && size != '0) |=>
         (state_ff == ST_RUN && i_ff == '0 && j_ff == '0 && k_ff == '0))
      else $error("Compute item did not start at the first element.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !(i_last && j_last && k_last)) |=> (state_ff == ST_RUN))
      else $error("Sequencer left the run state early.");

endmodule

`default_nettype wire

/* hw/rtl/smm_mac.sv */
`default_nettype none

module smm_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire smm_pkg::smm_tag_type               tag,
   input  wire logic [smm_pkg::DATA_W-1:0]         rd_data_a,
   input  wire logic [smm_pkg::DATA_W-1:0]         rd_data_b,
   output logic                                    rsp_valid,
   output logic [smm_pkg::IDX_W-1:0]               rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]               rsp_out_col,
   output logic signed [smm_pkg::ACC_W-1:0]        rsp_product_value,
   output logic                                    rsp_last_element
);

   import smm_pkg::*;

   smm_tag_type              tag1_ff, tag2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [ACC_W-1:0]  rsp_value_ff;
   logic                     rsp_last_ff;

   assign prod_in = $signed(rd_data_a) * $signed(rd_data_b);

   always_comb begin
      if (tag2_ff.first) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         tag1_ff.valid <= tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         rsp_valid_ff  <= tag2_ff.valid && tag2_ff.last_k;
         rsp_last_ff   <= tag2_ff.valid && tag2_ff.last_k && tag2_ff.last_elem;
      end
      tag1_ff.first     <= tag.first;
      tag1_ff.last_k    <= tag.last_k;
      tag1_ff.last_elem <= tag.last_elem;
      tag1_ff.row       <= tag.row;
      tag1_ff.col       <= tag.col;
      tag2_ff.first     <= tag1_ff.first;
      tag2_ff.last_k    <= tag1_ff.last_k;
      tag2_ff.last_elem <= tag1_ff.last_elem;
      tag2_ff.row       <= tag1_ff.row;
      tag2_ff.col       <= tag1_ff.col;
      prod_ff           <= prod_in;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      rsp_row_ff   <= tag2_ff.row;
      rsp_col_ff   <= tag2_ff.col;
      rsp_value_ff <= acc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last_element  = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/square_matrix_multiply_top.sv */
`default_nettype none

// Square matrix multiplier for signed Q8.8 matrices of up to MAX_DIM by MAX_DIM.
// An item is accepted at a clock edge with start high and busy low. Opcode
// OP_WRITE_A or OP_WRITE_B stores one element at the accepting edge, so loads
// run at one item per cycle while busy is low and produce no result. A compute
// item multiplies the top-left n by n corners, n being matrix_size limited to
// MAX_DIM, and keeps busy high while it runs one multiply-accumulate per cycle,
// because each cycle reads one word from each of the two element memories.
// Every result passes the memory read register, the product register and the
// response register, and results leave in row-major order, the last one
// flagged by rsp_last_element. Each result is shown for exactly one cycle with
// rsp_valid high; the receiver cannot stall the block. A new item may be
// accepted as soon as busy is low. matrix_size is written over the APB port
// at byte address 0 and resets to 8. Reset clears the control state only; the
// element memories hold unknown data until written.
module square_matrix_multiply_top #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [smm_pkg::IDX_W-1:0]          req_row_index,
   input  wire logic [smm_pkg::IDX_W-1:0]          req_col_index,
   input  wire logic signed [smm_pkg::DATA_W-1:0]  req_element_value,
   output logic                                    rsp_valid,
   output logic [smm_pkg::IDX_W-1:0]               rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]               rsp_out_col,
   output logic signed [smm_pkg::ACC_W-1:0]        rsp_product_value,
   output logic                                    rsp_last_element,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [2:0]                         paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);

   import smm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] active_size;
   logic              accept;
   logic              in_range;
   logic              wr_en_a, wr_en_b;
   logic              start_compute;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] rd_data_a, rd_data_b;
   smm_tag_type       tag;

   assign pready = 1'b1;

   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && paddr[2] == REG_MATRIX_SIZE) begin
         size_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {{(32 - SIZE_W){1'b0}}, size_ff} : '0;

   assign active_size = (size_ff > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_ff;

   assign accept        = start && !busy;
   assign in_range      = ({1'b0, req_row_index} < SIZE_W'(MAX_DIM))
                          && ({1'b0, req_col_index} < SIZE_W'(MAX_DIM));
   assign wr_en_a       = accept && in_range && (req_opcode == OP_WRITE_A);
   assign wr_en_b       = accept && in_range && (req_opcode == OP_WRITE_B);
   assign start_compute = accept && (req_opcode == OP_COMPUTE);
   assign wr_addr       = ADDR_W'(int'(req_row_index) * MAX_DIM + int'(req_col_index));

   smm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   smm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   smm_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start_compute (start_compute),
      .size          (active_size),
      .busy          (busy),
      .rd_addr_a     (rd_addr_a),
      .rd_addr_b     (rd_addr_b),
      .tag           (tag)
   );

   smm_mac u_mac (
      .clock             (clock),
      .reset             (reset),
      .tag               (tag),
      .rd_data_a         (rd_data_a),
      .rd_data_b         (rd_data_b),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_element  (rsp_last_element)
   );

endmodule

`default_nettype wire
